FILE: rtl/tgarle_pkg.sv
// Package for the TGA run-length pixel decoder.
// Holds payload structs, command and config types, state enums and a helper function.
// No dependencies.
`timescale 1ns / 1ps

package tgarle_pkg;

  // Field widths
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned DimW      = 13;
  localparam int unsigned WalkW     = 12;
  localparam int unsigned PixW      = 2 * DimW;

  // Largest image side; larger register values are clamped to this
  localparam logic [DimW-1:0] MaxDimension = 13'd4096;

  // Reset values of the configuration registers
  localparam logic [DimW-1:0] ResetWidth  = 13'd256;
  localparam logic [DimW-1:0] ResetHeight = 13'd256;
  localparam logic [2:0]      BppThree    = 3'd3;
  localparam logic [2:0]      BppFour     = 3'd4;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_RLE_MODE        = 3'd2,
    CFG_BYTES_PER_PIXEL = 3'd3,
    CFG_REVERSE_COLUMNS = 3'd4,
    CFG_REVERSE_ROWS    = 3'd5
  } cfg_reg_e;

  // Open packet kind
  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_RUN  = 2'd1,
    PK_RAW  = 2'd2
  } packet_kind_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_EMIT,
    BS_WALK
  } back_state_e;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [WalkW-1:0] start_column;
    logic [WalkW-1:0] start_row;
    logic [7:0]       repeat_res;
    logic             image_done;
    logic             run_clamped;
  } out_t;

  // Command from front end to back end
  typedef struct packed {
    logic        restart;    // move walk to start corner and clear progress
    logic        has_pixel;  // a colour completed
    logic [23:0] color;      // {red, green, blue}
    logic [7:0]  want;       // requested repeat, 1..128
  } cmd_t;

  // Settings seen by the front end
  typedef struct packed {
    logic rle_mode;
    logic bpp_four;
  } front_cfg_t;

  // Settings seen by the back end (sizes already clamped)
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            reverse_columns;
    logic            reverse_rows;
  } walk_cfg_t;

  // Clamp a size register into 1..MaxDimension
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > MaxDimension) begin
      r = MaxDimension;
    end
    return r;
  endfunction

endpackage

FILE: rtl/tgarle_fifo.sv
// Short command queue between the decoder front end and the walk back end.
// Register based, one push and one pop per cycle. Uses tgarle_pkg::cmd_t.
`timescale 1ns / 1ps

module tgarle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tgarle_pkg::cmd_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tgarle_pkg::cmd_t  head_o
);

  localparam int unsigned AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);

  tgarle_pkg::cmd_t   mem_q [DEPTH];
  logic [AddrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CountW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/tgarle_front.sv
// Front end: accepts pixel-data bytes, parses packet headers and gathers colours.
// Emits restart and pixel commands into the queue. Depends on tgarle_pkg.
`timescale 1ns / 1ps

module tgarle_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tgarle_pkg::front_cfg_t  cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  tgarle_pkg::in_t         in_data_i,
  output logic                    push_o,
  output tgarle_pkg::cmd_t        push_data_o,
  input  logic                    full_i
);

  tgarle_pkg::packet_kind_e kind_q, kind_d, kind_c;
  logic [7:0]  left_q, left_d, left_c;
  logic [1:0]  pos_q, pos_d, pos_c;
  logic [23:0] color_q, color_d, color_c;
  logic        accept;
  logic        pixel_done;
  logic        last_byte;
  logic [7:0]  want;
  logic [7:0]  b;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;

  // Decode one byte against the (frame-start cleared) state
  always_comb begin
    kind_c  = in_data_i.frame_start ? tgarle_pkg::PK_NONE : kind_q;
    left_c  = in_data_i.frame_start ? 8'd0  : left_q;
    pos_c   = in_data_i.frame_start ? 2'd0  : pos_q;
    color_c = in_data_i.frame_start ? 24'd0 : color_q;

    kind_d     = kind_c;
    left_d     = left_c;
    pos_d      = pos_c;
    color_d    = color_c;
    pixel_done = 1'b0;
    want       = 8'd1;
    last_byte  = 1'b0;

    if (cfg_i.rle_mode && kind_c == tgarle_pkg::PK_NONE) begin
      // packet header: bit 7 selects run, low bits give count - 1
      kind_d = b[7] ? tgarle_pkg::PK_RUN : tgarle_pkg::PK_RAW;
      left_d = {1'b0, b[6:0]} + 8'd1;
      pos_d  = 2'd0;
    end else begin
      // bytes arrive blue, green, red; a fourth byte is dropped
      case (pos_c)
        2'd0:    color_d = {color_c[23:8], b};
        2'd1:    color_d = {color_c[23:16], b, color_c[7:0]};
        2'd2:    color_d = {b, color_c[15:0]};
        default: color_d = color_c;
      endcase
      last_byte = cfg_i.bpp_four ? (pos_c == 2'd3) : (pos_c >= 2'd2);
      pos_d     = last_byte ? 2'd0 : pos_c + 2'd1;
      if (last_byte) begin
        pixel_done = 1'b1;
        if (cfg_i.rle_mode) begin
          if (kind_c == tgarle_pkg::PK_RUN) begin
            want   = left_c;
            kind_d = tgarle_pkg::PK_NONE;
            left_d = 8'd0;
          end else if (left_c <= 8'd1) begin
            kind_d = tgarle_pkg::PK_NONE;
            left_d = 8'd0;
          end else begin
            left_d = left_c - 8'd1;
          end
        end
      end
    end
  end

  // Command to the back end
  assign push_o                = accept && (in_data_i.frame_start || pixel_done);
  assign push_data_o.restart   = in_data_i.frame_start;
  assign push_data_o.has_pixel = pixel_done;
  assign push_data_o.color     = color_d;
  assign push_data_o.want      = want;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= tgarle_pkg::PK_NONE;
      left_q  <= 8'd0;
      pos_q   <= 2'd0;
      color_q <= 24'd0;
    end else if (accept) begin
      kind_q  <= kind_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      color_q <= color_d;
    end
  end

endmodule

FILE: rtl/tgarle_back.sv
// Back end: clamps runs against the image size, emits records and steps the walk.
// Pops commands from the queue and drives the output register. Depends on tgarle_pkg.
`timescale 1ns / 1ps

module tgarle_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tgarle_pkg::walk_cfg_t  cfg_i,
  input  logic                   empty_i,
  input  tgarle_pkg::cmd_t       head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tgarle_pkg::out_t       out_data_o
);

  localparam int unsigned DimW  = tgarle_pkg::DimW;
  localparam int unsigned WalkW = tgarle_pkg::WalkW;
  localparam int unsigned PixW  = tgarle_pkg::PixW;

  tgarle_pkg::back_state_e state_q, state_d;
  tgarle_pkg::cmd_t        cmd_q, cmd_d;
  tgarle_pkg::out_t        out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic [WalkW-1:0]        col_q, col_d;
  logic [WalkW-1:0]        row_q, row_d;
  logic [PixW-1:0]         done_px_q, done_px_d;
  logic                    finished_q, finished_d;
  logic [7:0]              left_q, left_d;
  logic [PixW-1:0]         total_q;

  logic [PixW-1:0]  remaining;
  logic             none_left;
  logic             clamp;
  logic [7:0]       n;
  logic             last_px;
  logic             out_free;
  logic             load_rec;
  logic [DimW-1:0]  col_ext;
  logic [DimW-1:0]  room;
  logic [WalkW-1:0] row_step;

  // Image pixel count, registered off the size settings
  always_ff @(posedge clk_i) begin
    total_q <= cfg_i.width * cfg_i.height;
  end

  // Run clamp against pixels still left in the image
  assign remaining = total_q - done_px_q;
  assign none_left = (done_px_q >= total_q);
  assign clamp     = ({{(PixW-8){1'b0}}, cmd_q.want} > remaining);
  assign n         = clamp ? remaining[7:0] : cmd_q.want;
  assign last_px   = ({{(PixW-8){1'b0}}, n} == remaining);
  assign out_free  = !out_valid_q || out_ready_i;

  // Pixels that fit before the end of the current row
  assign col_ext  = {1'b0, col_q};
  assign room     = cfg_i.reverse_columns ? col_ext + DimW'(1) :
                    (col_ext >= cfg_i.width) ? DimW'(1) : cfg_i.width - col_ext;
  assign row_step = cfg_i.reverse_rows ? row_q - WalkW'(1) : row_q + WalkW'(1);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    col_d       = col_q;
    row_d       = row_q;
    done_px_d   = done_px_q;
    finished_d  = finished_q;
    left_d      = left_q;
    pop_o       = 1'b0;
    load_rec    = 1'b0;

    case (state_q)
      tgarle_pkg::BS_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          if (head_i.restart) begin
            col_d      = cfg_i.reverse_columns ? WalkW'(cfg_i.width - DimW'(1)) : '0;
            row_d      = cfg_i.reverse_rows ? WalkW'(cfg_i.height - DimW'(1)) : '0;
            done_px_d  = '0;
            finished_d = 1'b0;
          end
          state_d = head_i.has_pixel ? tgarle_pkg::BS_EMIT : tgarle_pkg::BS_IDLE;
        end
      end

      tgarle_pkg::BS_EMIT: begin
        if (finished_q || none_left) begin
          // nothing left to cover: drop the pixel
          finished_d = 1'b1;
          state_d    = tgarle_pkg::BS_IDLE;
        end else if (out_free) begin
          load_rec           = 1'b1;
          out_d.red          = cmd_q.color[23:16];
          out_d.green        = cmd_q.color[15:8];
          out_d.blue         = cmd_q.color[7:0];
          out_d.start_column = col_q;
          out_d.start_row    = row_q;
          out_d.repeat_res   = n;
          out_d.image_done   = last_px;
          out_d.run_clamped  = clamp;
          out_valid_d        = 1'b1;
          done_px_d          = done_px_q + PixW'(n);
          finished_d         = last_px;
          left_d             = n;
          state_d            = tgarle_pkg::BS_WALK;
        end
      end

      tgarle_pkg::BS_WALK: begin
        // consume the rest of the current row, or finish inside it
        if ({{(DimW-8){1'b0}}, left_q} < room) begin
          col_d   = cfg_i.reverse_columns ? col_q - WalkW'(left_q) : col_q + WalkW'(left_q);
          left_d  = 8'd0;
          state_d = tgarle_pkg::BS_IDLE;
        end else begin
          col_d   = cfg_i.reverse_columns ? WalkW'(cfg_i.width - DimW'(1)) : '0;
          row_d   = row_step;
          left_d  = left_q - room[7:0];
          state_d = (left_d == 8'd0) ? tgarle_pkg::BS_IDLE : tgarle_pkg::BS_WALK;
        end
      end

      default: state_d = tgarle_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgarle_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      done_px_q   <= '0;
      finished_q  <= 1'b0;
      left_q      <= 8'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
      done_px_q   <= done_px_d;
      finished_q  <= finished_d;
      left_q      <= left_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The walk never runs with nothing left to step
  a_walk_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tgarle_pkg::BS_WALK |-> left_q != 8'd0)
    else $error("walk state with zero pixels left");

  // A record is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rec |-> (!out_valid_q || out_ready_i))
    else $error("record overwrote a pending transaction");

  // Pending records always cover 1..128 pixels
  a_repeat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.repeat_res != 8'd0) && (out_q.repeat_res <= 8'd128))
    else $error("record repeat out of range");

  // A record reaching the last pixel finishes the image
  a_done_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rec && last_px |=> finished_q)
    else $error("image end not latched");

endmodule

FILE: rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: config registers, front end,
// command queue and back end. Depends on tgarle_pkg, tgarle_front, tgarle_fifo, tgarle_back.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_data_i  (tgarle_pkg::in_t)
//   out      output     out_valid_o / out_ready_i out_data_o (tgarle_pkg::out_t)
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// The front end takes one byte per cycle while the queue has room.
// The back end handles each record in pop, emit and walk steps, repeating the walk step
// for each further row boundary the run crosses; emit waits for a free output register.
// Raw 24-bit data sustains about one byte per cycle while the output keeps up; long runs
// are set by the walk. Reset clears walk, packet and queue state at once; no clearing pass.
// Output stalls back up through the queue to in_ready_o.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  tgarle_pkg::in_t                       in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output tgarle_pkg::out_t                      out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [tgarle_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [tgarle_pkg::CfgDataW-1:0]       cfg_data_i
);

  logic [tgarle_pkg::DimW-1:0] width_q, height_q;
  logic                        rle_q;
  logic [2:0]                  bpp_q;
  logic                        rev_cols_q, rev_rows_q;

  tgarle_pkg::front_cfg_t front_cfg;
  tgarle_pkg::walk_cfg_t  walk_cfg;
  tgarle_pkg::cmd_t       push_data, head;
  logic                   push, pop, full, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= tgarle_pkg::ResetWidth;
      height_q   <= tgarle_pkg::ResetHeight;
      rle_q      <= 1'b0;
      bpp_q      <= tgarle_pkg::BppThree;
      rev_cols_q <= 1'b0;
      rev_rows_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tgarle_pkg::CFG_IMAGE_WIDTH:     width_q    <= cfg_data_i;
        tgarle_pkg::CFG_IMAGE_HEIGHT:    height_q   <= cfg_data_i;
        tgarle_pkg::CFG_RLE_MODE:        rle_q      <= cfg_data_i[0];
        tgarle_pkg::CFG_BYTES_PER_PIXEL: bpp_q      <= cfg_data_i[2:0];
        tgarle_pkg::CFG_REVERSE_COLUMNS: rev_cols_q <= cfg_data_i[0];
        tgarle_pkg::CFG_REVERSE_ROWS:    rev_rows_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign front_cfg.rle_mode        = rle_q;
  assign front_cfg.bpp_four        = (bpp_q == tgarle_pkg::BppFour);
  assign walk_cfg.width            = tgarle_pkg::eff_dim(width_q);
  assign walk_cfg.height           = tgarle_pkg::eff_dim(height_q);
  assign walk_cfg.reverse_columns  = rev_cols_q;
  assign walk_cfg.reverse_rows     = rev_rows_q;

  tgarle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (front_cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tgarle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  tgarle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (walk_cfg),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
